@@ rtl/clle_pkg.sv @@
// ----------------------------------------------------------------------------
// clle_pkg
// shared constants, codes and types of the cursor linked list engine
// ----------------------------------------------------------------------------
package clle_pkg;

    localparam int CELL_COUNT   = 255;
    localparam int ELEMENT_BITS = 32;

    localparam int LINK_DEPTH = CELL_COUNT + 1;
    localparam int LINK_W     = $clog2(LINK_DEPTH);
    localparam int STEP_W     = $clog2(CELL_COUNT + 2);

    localparam int OP_W     = 3;
    localparam int POS_W    = 8;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    typedef logic [LINK_W-1:0] link_t;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE   = 3'd0,
        OP_INSERT   = 3'd1,
        OP_DELETE   = 3'd2,
        OP_ACCESS   = 3'd3,
        OP_NEXT     = 3'd4,
        OP_LAST     = 3'd5,
        OP_IS_EMPTY = 3'd6,
        OP_DESTROY  = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 2'd0,
        STS_INVALID = 2'd1,
        STS_FULL    = 2'd2,
        STS_NONE    = 2'd3
    } status_t;

    typedef struct packed {
        logic  rd_en;
        link_t rd_addr;
        logic  wr_en;
        link_t wr_addr;
        link_t wr_data;
    } link_req_t;

    function automatic link_t to_link(logic [POS_W-1:0] x);
        logic [63:0] w;
        w = 64'(x);
        return w[LINK_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] to_pos(link_t x);
        logic [63:0] w;
        w = 64'(x);
        return w[POS_W-1:0];
    endfunction

    function automatic logic cell_ok(logic [POS_W-1:0] x);
        return (x != '0) && (32'(x) <= 32'(CELL_COUNT));
    endfunction

endpackage

@@ rtl/clle_if.sv @@
// ----------------------------------------------------------------------------
// clle_if
// valid/ready channels for commands and results of the linked list engine
// ----------------------------------------------------------------------------
interface clle_in_if;
    import clle_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    list_head;
    logic [WORD_W-1:0]   element_in;

    modport source (
        output valid, operation, position, list_head, element_in,
        input  ready
    );

    modport sink (
        input  valid, operation, position, list_head, element_in,
        output ready
    );
endinterface

interface clle_out_if;
    import clle_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position_out;
    logic [WORD_W-1:0]   element_out;
    logic                list_empty;

    modport source (
        output valid, status, position_out, element_out, list_empty,
        input  ready
    );

    modport sink (
        input  valid, status, position_out, element_out, list_empty,
        output ready
    );
endinterface

@@ rtl/cursor_linked_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_unit
// several singly linked lists sharing one cell store with a free list
// ----------------------------------------------------------------------------
// One command is taken at a time and answered by exactly one result. All
// link reads go through the single read port of the link store, one
// link read per cycle, so the cost of a command is set by the number of
// links it touches. A delete that finds nothing after the position ends
// early, as does an access that finds nothing after the position or the
// header. An invalid cell or a full store is answered without a link read.
// The result sits in an output register, so a stalled result only holds the
// next command at its end. No clearing pass is needed after reset.
module cursor_linked_list_engine_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    clle_in_if.sink                     cmd,
    clle_out_if.source                  rsp,
    input  logic                        cfg_wr_en,
    input  logic [clle_pkg::WORD_W-1:0] cfg_wr_data
);
    import clle_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_LINK1  = 10'b00_0000_0010,
        S_LINK2  = 10'b00_0000_0100,
        S_WRITE2 = 10'b00_0000_1000,
        S_WALK   = 10'b00_0001_0000,
        S_DTEST  = 10'b00_0010_0000,
        S_DWRP   = 10'b00_0100_0000,
        S_DWRT   = 10'b00_1000_0000,
        S_ELEM   = 10'b01_0000_0000,
        S_FIN    = 10'b10_0000_0000
    } state_t;

    state_t              state_reg,      state_next;
    op_t                 op_reg,         op_next;
    link_t               pos_reg,        pos_next;
    link_t               free_reg,       free_next;
    link_t               p_reg,          p_next;
    link_t               t_reg,          t_next;
    link_t               u_reg,          u_next;
    logic [STEP_W-1:0]   k_reg,          k_next;
    logic                flag_reg,       flag_next;
    status_t             res_status_reg, res_status_next;
    link_t               res_pos_reg,    res_pos_next;
    logic [WORD_W-1:0]   res_elem_reg,   res_elem_next;
    logic                res_empty_reg,  res_empty_next;
    logic                out_valid_reg,  out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [POS_W-1:0]    out_pos_reg,    out_pos_next;
    logic [WORD_W-1:0]   out_elem_reg,   out_elem_next;
    logic                out_empty_reg,  out_empty_next;
    logic [WORD_W-1:0]   empty_value_reg;

    link_req_t           link_req;
    link_t               link_rd;

    logic                elem_we;
    logic                elem_re;
    link_t               elem_ra;
    logic [ELEMENT_BITS-1:0] elem_q;
    logic [ELEMENT_BITS-1:0] elem_wd;
    logic [63:0]         elem_in_ext;
    logic [63:0]         elem_q_ext;

    op_t                 cmd_op;
    link_t               cmd_pos;
    link_t               cmd_head;
    logic                pos_ok;
    logic                head_ok;

    clle_link_store u_links (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (link_req),
        .rd_data (link_rd)
    );

    clle_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (LINK_DEPTH)
    ) u_elements (
        .clk     (clk),
        .wr_en   (elem_we),
        .wr_addr (free_reg),
        .wr_data (elem_wd),
        .rd_en   (elem_re),
        .rd_addr (elem_ra),
        .rd_data (elem_q)
    );

    assign cmd_op      = op_t'(cmd.operation);
    assign cmd_pos     = to_link(cmd.position);
    assign cmd_head    = to_link(cmd.list_head);
    assign pos_ok      = cell_ok(cmd.position);
    assign head_ok     = cell_ok(cmd.list_head);
    assign elem_in_ext = 64'(cmd.element_in);
    assign elem_wd     = elem_in_ext[ELEMENT_BITS-1:0];
    assign elem_q_ext  = 64'(elem_q);
    assign elem_ra     = link_rd;

    assign cmd.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.position_out = out_pos_reg;
    assign rsp.element_out  = out_elem_reg;
    assign rsp.list_empty   = out_empty_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        pos_next        = pos_reg;
        free_next       = free_reg;
        p_next          = p_reg;
        t_next          = t_reg;
        u_next          = u_reg;
        k_next          = k_reg;
        flag_next       = flag_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_elem_next   = res_elem_reg;
        res_empty_next  = res_empty_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_elem_next   = out_elem_reg;
        out_empty_next  = out_empty_reg;
        link_req        = '0;
        elem_we         = 1'b0;
        elem_re         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next         = cmd_op;
                    pos_next        = cmd_pos;
                    p_next          = cmd_head;
                    k_next          = '0;
                    res_status_next = STS_OK;
                    res_pos_next    = '0;
                    res_elem_next   = empty_value_reg;
                    res_empty_next  = 1'b0;
                    state_next      = S_LINK1;
                    unique case (cmd_op)
                        OP_CREATE:
                        begin
                            if (free_reg == '0)
                            begin
                                res_status_next = STS_FULL;
                                state_next      = S_FIN;
                            end
                            else
                            begin
                                t_next           = free_reg;
                                link_req.rd_en   = 1'b1;
                                link_req.rd_addr = free_reg;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (!pos_ok)
                            begin
                                res_status_next = STS_INVALID;
                                state_next      = S_FIN;
                            end
                            else if (free_reg == '0)
                            begin
                                res_status_next = STS_FULL;
                                state_next      = S_FIN;
                            end
                            else
                            begin
                                t_next           = free_reg;
                                link_req.rd_en   = 1'b1;
                                link_req.rd_addr = free_reg;
                                elem_we          = 1'b1;
                            end
                        end
                        OP_DELETE, OP_NEXT:
                        begin
                            if (!pos_ok)
                            begin
                                res_status_next = STS_INVALID;
                                state_next      = S_FIN;
                            end
                            else
                            begin
                                link_req.rd_en   = 1'b1;
                                link_req.rd_addr = cmd_pos;
                            end
                        end
                        OP_ACCESS:
                        begin
                            if (!pos_ok || !head_ok)
                            begin
                                res_status_next = STS_INVALID;
                                state_next      = S_FIN;
                            end
                            else
                            begin
                                link_req.rd_en   = 1'b1;
                                link_req.rd_addr = cmd_head;
                            end
                        end
                        OP_LAST, OP_IS_EMPTY, OP_DESTROY:
                        begin
                            if (!head_ok)
                            begin
                                res_status_next = STS_INVALID;
                                state_next      = S_FIN;
                            end
                            else
                            begin
                                link_req.rd_en   = 1'b1;
                                link_req.rd_addr = cmd_head;
                                if (cmd_op == OP_LAST)
                                begin
                                    state_next = S_WALK;
                                end
                            end
                        end
                    endcase
                end
            end

            S_LINK1:
            begin
                state_next = S_FIN;
                unique case (op_reg)
                    OP_CREATE:
                    begin
                        free_next        = link_rd;
                        link_req.wr_en   = 1'b1;
                        link_req.wr_addr = t_reg;
                        link_req.wr_data = '0;
                        res_pos_next     = t_reg;
                    end
                    OP_INSERT:
                    begin
                        u_next           = link_rd;
                        link_req.rd_en   = 1'b1;
                        link_req.rd_addr = pos_reg;
                        state_next       = S_LINK2;
                    end
                    OP_DELETE:
                    begin
                        if (link_rd == '0)
                        begin
                            res_status_next = STS_NONE;
                        end
                        else
                        begin
                            t_next           = link_rd;
                            link_req.rd_en   = 1'b1;
                            link_req.rd_addr = link_rd;
                            state_next       = S_LINK2;
                        end
                    end
                    OP_ACCESS:
                    begin
                        flag_next        = (link_rd == '0);
                        link_req.rd_en   = 1'b1;
                        link_req.rd_addr = pos_reg;
                        state_next       = S_LINK2;
                    end
                    OP_NEXT:
                    begin
                        res_pos_next = link_rd;
                    end
                    OP_IS_EMPTY:
                    begin
                        res_empty_next = (link_rd == '0);
                    end
                    OP_DESTROY:
                    begin
                        t_next     = link_rd;
                        state_next = S_DTEST;
                    end
                    OP_LAST:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end

            S_LINK2:
            begin
                state_next = S_FIN;
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        // an insert after the cell just taken leaves it unlinked
                        link_req.wr_en   = 1'b1;
                        link_req.wr_addr = pos_reg;
                        link_req.wr_data = t_reg;
                        free_next        = u_reg;
                        u_next           = (pos_reg == t_reg) ? '0 : link_rd;
                        state_next       = S_WRITE2;
                    end
                    OP_DELETE:
                    begin
                        link_req.wr_en   = 1'b1;
                        link_req.wr_addr = pos_reg;
                        link_req.wr_data = link_rd;
                        state_next       = S_WRITE2;
                    end
                    OP_ACCESS:
                    begin
                        if (flag_reg || (link_rd == '0))
                        begin
                            res_status_next = STS_NONE;
                        end
                        else
                        begin
                            elem_re    = 1'b1;
                            state_next = S_ELEM;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end

            S_WRITE2:
            begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = t_reg;
                if (op_reg == OP_INSERT)
                begin
                    link_req.wr_data = u_reg;
                end
                else
                begin
                    link_req.wr_data = free_reg;
                    free_next        = t_reg;
                end
                state_next = S_FIN;
            end

            S_WALK:
            begin
                if (link_rd == '0)
                begin
                    res_pos_next = p_reg;
                    state_next   = S_FIN;
                end
                else
                begin
                    p_next = link_rd;
                    if (k_reg == STEP_W'(CELL_COUNT))
                    begin
                        res_pos_next = link_rd;
                        state_next   = S_FIN;
                    end
                    else
                    begin
                        k_next           = k_reg + STEP_W'(1);
                        link_req.rd_en   = 1'b1;
                        link_req.rd_addr = link_rd;
                    end
                end
            end

            S_DTEST:
            begin
                if ((t_reg == '0) || (k_reg == STEP_W'(CELL_COUNT + 1)))
                begin
                    // header goes back on the free list last
                    link_req.wr_en   = 1'b1;
                    link_req.wr_addr = p_reg;
                    link_req.wr_data = free_reg;
                    free_next        = p_reg;
                    state_next       = S_FIN;
                end
                else
                begin
                    link_req.rd_en   = 1'b1;
                    link_req.rd_addr = t_reg;
                    state_next       = S_DWRP;
                end
            end

            S_DWRP:
            begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = p_reg;
                link_req.wr_data = link_rd;
                u_next           = link_rd;
                state_next       = S_DWRT;
            end

            S_DWRT:
            begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = t_reg;
                link_req.wr_data = free_reg;
                free_next        = t_reg;
                t_next           = (t_reg == p_reg) ? free_reg : u_reg;
                k_next           = k_reg + STEP_W'(1);
                state_next       = S_DTEST;
            end

            S_ELEM:
            begin
                res_elem_next = elem_q_ext[WORD_W-1:0];
                state_next    = S_FIN;
            end

            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pos_next    = to_pos(res_pos_reg);
                    out_elem_next   = res_elem_reg;
                    out_empty_next  = res_empty_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            free_reg        <= LINK_W'(1);
            k_reg           <= '0;
            out_valid_reg   <= 1'b0;
            empty_value_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                empty_value_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        pos_reg        <= pos_next;
        p_reg          <= p_next;
        t_reg          <= t_next;
        u_reg          <= u_next;
        flag_reg       <= flag_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_elem_reg   <= res_elem_next;
        res_empty_reg  <= res_empty_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_elem_reg   <= out_elem_next;
        out_empty_reg  <= out_empty_next;
    end

    // one transaction in flight: no new command right after an accept
    a_single_command: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("command accepted while another is in progress");

    // free list head always names a cell of the store or none
    a_free_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(free_reg) <= 32'(CELL_COUNT))
        else $error("free list head out of range");

    // bounded walks never run past the step limit
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(k_reg) <= 32'(CELL_COUNT + 1))
        else $error("walk counter past its bound");

    // a finished command reaches the output register once it is free
    a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FIN) && (!out_valid_reg || rsp.ready)) |=> rsp.valid)
        else $error("finished command did not produce a result");

endmodule

@@ rtl/clle_ram.sv @@
// ----------------------------------------------------------------------------
// clle_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module clle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first on a same-address collision
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/clle_link_store.sv @@
// ----------------------------------------------------------------------------
// clle_link_store
// next-link store: ram plus per-entry valid bits that stand in for the
// reset contents (entry i links to i+1, the last entry links to none)
// ----------------------------------------------------------------------------
module clle_link_store (
    input  logic                clk,
    input  logic                rst_n,
    input  clle_pkg::link_req_t req,
    output clle_pkg::link_t     rd_data
);
    import clle_pkg::*;

    logic [LINK_DEPTH-1:0] valid_reg;
    logic                  hit_reg;
    link_t                 addr_reg;
    link_t                 ram_q;
    link_t                 default_link;

    clle_ram #(
        .WIDTH (LINK_W),
        .DEPTH (LINK_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_data),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                hit_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            addr_reg <= req.rd_addr;
        end
    end

    assign default_link = (addr_reg == LINK_W'(CELL_COUNT)) ? '0
                        : LINK_W'(32'(addr_reg) + 32'd1);

    assign rd_data = hit_reg ? ram_q : default_link;

endmodule
